// ===== design/m3i_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_pkg
// Shared constants of the 3x3 fixed-point matrix inverse pipeline.
// ----------------------------------------------------------------------------
package m3i_pkg;

   localparam int ELEM_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int NUM_ELEM       = 9;
   localparam int THR_WIDTH      = 31;

   localparam logic [THR_WIDTH-1:0] THR_RESET = THR_WIDTH'(1);

endpackage

// ===== design/matrix3x3_inverse_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3x3_inverse_top
// Inverse of a 3x3 signed fixed-point matrix through the adjugate and the
// determinant, with singular detection and saturating outputs.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one matrix per item (row-major elements), rsp_* carries the
//   inverse, the determinant and the singular flag; both use valid/ready.
//   csr_we with csr_wdata writes the singular threshold (reset value 1).
//   Fully pipelined: one item per cycle sustained while rsp_ready is high,
//   ELEM_WIDTH + 12 register stages. The depth is set by the divider, which
//   settles one quotient bit per stage.
//   Every stage has its own valid bit and loads whenever it is empty or the
//   stage after it moves, so bubbles close up under back-pressure; when
//   rsp_ready stays low the pipeline fills and req_ready drops, and nothing
//   is lost or repeated.
//   Synchronous reset empties the pipeline and restores the threshold.
//   A matrix whose determinant magnitude is zero or below the threshold gives
//   an all-zero inverse with rsp_singular high; rsp_determinant stays valid.
// ----------------------------------------------------------------------------
module matrix3x3_inverse_top #(
   parameter int ELEM_WIDTH = m3i_pkg::ELEM_WIDTH_DEF,
   parameter int FRAC_BITS  = m3i_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [m3i_pkg::THR_WIDTH-1:0]       csr_wdata,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [ELEM_WIDTH-1:0]        req_a_r0c0,
   input  logic signed [ELEM_WIDTH-1:0]        req_a_r0c1,
   input  logic signed [ELEM_WIDTH-1:0]        req_a_r0c2,
   input  logic signed [ELEM_WIDTH-1:0]        req_a_r1c0,
   input  logic signed [ELEM_WIDTH-1:0]        req_a_r1c1,
   input  logic signed [ELEM_WIDTH-1:0]        req_a_r1c2,
   input  logic signed [ELEM_WIDTH-1:0]        req_a_r2c0,
   input  logic signed [ELEM_WIDTH-1:0]        req_a_r2c1,
   input  logic signed [ELEM_WIDTH-1:0]        req_a_r2c2,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [ELEM_WIDTH-1:0]        rsp_inv_r0c0,
   output logic signed [ELEM_WIDTH-1:0]        rsp_inv_r0c1,
   output logic signed [ELEM_WIDTH-1:0]        rsp_inv_r0c2,
   output logic signed [ELEM_WIDTH-1:0]        rsp_inv_r1c0,
   output logic signed [ELEM_WIDTH-1:0]        rsp_inv_r1c1,
   output logic signed [ELEM_WIDTH-1:0]        rsp_inv_r1c2,
   output logic signed [ELEM_WIDTH-1:0]        rsp_inv_r2c0,
   output logic signed [ELEM_WIDTH-1:0]        rsp_inv_r2c1,
   output logic signed [ELEM_WIDTH-1:0]        rsp_inv_r2c2,
   output logic signed [ELEM_WIDTH-1:0]        rsp_determinant,
   output logic                                rsp_singular
);
   localparam int W  = ELEM_WIDTH;
   localparam int NE = m3i_pkg::NUM_ELEM;

   logic [m3i_pkg::THR_WIDTH-1:0]  thr_ff;

   logic signed [W-1:0]            a [NE];
   logic                           cof_valid;
   logic                           cof_ready;
   logic signed [W-1:0]            cof_row0 [3];
   logic signed [2*W:0]            cof_val [NE];
   logic                           det_valid;
   logic                           det_ready;
   logic [2*W+2*FRAC_BITS:0]       det_num [NE];
   logic [NE-1:0]                  det_nneg;
   logic [3*W+2:0]                 det_dmag;
   logic                           det_dneg;
   logic signed [W-1:0]            det_val;
   logic                           det_sing;
   logic signed [W-1:0]            inv [NE];

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= m3i_pkg::THR_RESET;
      end else if (csr_we) begin
         thr_ff <= csr_wdata;
      end
   end

   assign a[0] = req_a_r0c0;
   assign a[1] = req_a_r0c1;
   assign a[2] = req_a_r0c2;
   assign a[3] = req_a_r1c0;
   assign a[4] = req_a_r1c1;
   assign a[5] = req_a_r1c2;
   assign a[6] = req_a_r2c0;
   assign a[7] = req_a_r2c1;
   assign a[8] = req_a_r2c2;

   m3i_cofactor #(
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_cofactor (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_a      (a),
      .out_valid (cof_valid),
      .out_ready (cof_ready),
      .out_row0  (cof_row0),
      .out_cof   (cof_val)
   );

   m3i_det #(
      .ELEM_WIDTH (ELEM_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_det (
      .clock     (clock),
      .reset     (reset),
      .thr       (thr_ff),
      .in_valid  (cof_valid),
      .in_ready  (cof_ready),
      .in_row0   (cof_row0),
      .in_cof    (cof_val),
      .out_valid (det_valid),
      .out_ready (det_ready),
      .out_num   (det_num),
      .out_nneg  (det_nneg),
      .out_dmag  (det_dmag),
      .out_dneg  (det_dneg),
      .out_det   (det_val),
      .out_sing  (det_sing)
   );

   m3i_divide #(
      .ELEM_WIDTH (ELEM_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_divide (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (det_valid),
      .in_ready  (det_ready),
      .in_num    (det_num),
      .in_nneg   (det_nneg),
      .in_dmag   (det_dmag),
      .in_dneg   (det_dneg),
      .in_det    (det_val),
      .in_sing   (det_sing),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_inv   (inv),
      .out_det   (rsp_determinant),
      .out_sing  (rsp_singular)
   );

   assign rsp_inv_r0c0 = inv[0];
   assign rsp_inv_r0c1 = inv[1];
   assign rsp_inv_r0c2 = inv[2];
   assign rsp_inv_r1c0 = inv[3];
   assign rsp_inv_r1c1 = inv[4];
   assign rsp_inv_r1c2 = inv[5];
   assign rsp_inv_r2c0 = inv[6];
   assign rsp_inv_r2c1 = inv[7];
   assign rsp_inv_r2c2 = inv[8];

   // a singular item never carries a nonzero inverse element
   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |->
         (rsp_inv_r0c0 == '0) && (rsp_inv_r0c1 == '0) && (rsp_inv_r0c2 == '0) &&
         (rsp_inv_r1c0 == '0) && (rsp_inv_r1c1 == '0) && (rsp_inv_r1c2 == '0) &&
         (rsp_inv_r2c0 == '0) && (rsp_inv_r2c1 == '0) && (rsp_inv_r2c2 == '0))
      else $error("singular item with nonzero inverse");

   // an empty output stage lets the whole chain take an item
   a_ready_when_drained: assert property (@(posedge clock)
      !rsp_valid |-> req_ready)
      else $error("input stalled while output stage empty");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

// ===== design/m3i_cofactor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_cofactor
// Input register, the eighteen 2x2 minor products and the nine adjugate
// elements (three register stages).
// ----------------------------------------------------------------------------
module m3i_cofactor #(
   parameter int ELEM_WIDTH = m3i_pkg::ELEM_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic signed [ELEM_WIDTH-1:0] in_a [m3i_pkg::NUM_ELEM],
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic signed [ELEM_WIDTH-1:0] out_row0 [3],
   output logic signed [2*ELEM_WIDTH:0] out_cof [m3i_pkg::NUM_ELEM]
);
   localparam int W  = ELEM_WIDTH;
   localparam int CW = 2*W + 1;
   localparam int NE = m3i_pkg::NUM_ELEM;
   localparam int NS = 3;

   // adjugate element k = a[MP]*a[MQ] - a[MS]*a[MU], row-major
   localparam int MP [NE] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
   localparam int MQ [NE] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
   localparam int MS [NE] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
   localparam int MU [NE] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

   logic [NS-1:0]         v_ff;
   logic [NS:0]           rdy;
   logic signed [W-1:0]   a_ff    [NE];
   logic signed [2*W-1:0] prod_in [2*NE];
   logic signed [2*W-1:0] prod_ff [2*NE];
   logic signed [W-1:0]   row1_ff [3];
   logic signed [CW-1:0]  cof_in  [NE];
   logic signed [CW-1:0]  cof_ff  [NE];
   logic signed [W-1:0]   row2_ff [3];

   always_comb begin
      rdy[NS] = out_ready;
      for (int k = NS-1; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int k = 1; k < NS; k++) begin
            if (rdy[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   always_comb begin
      for (int k = 0; k < NE; k++) begin
         prod_in[2*k]   = a_ff[MP[k]] * a_ff[MQ[k]];
         prod_in[2*k+1] = a_ff[MS[k]] * a_ff[MU[k]];
         cof_in[k] = {prod_ff[2*k][2*W-1], prod_ff[2*k]}
                   - {prod_ff[2*k+1][2*W-1], prod_ff[2*k+1]};
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         a_ff <= in_a;
      end
      if (rdy[1]) begin
         prod_ff <= prod_in;
         for (int j = 0; j < 3; j++) begin
            row1_ff[j] <= a_ff[j];
         end
      end
      if (rdy[2]) begin
         cof_ff  <= cof_in;
         row2_ff <= row1_ff;
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[NS-1];
   assign out_row0  = row2_ff;
   assign out_cof   = cof_ff;

endmodule

// ===== design/m3i_det.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_det
// Determinant by first-row expansion, magnitudes and signs, rounded and
// saturated determinant, singular test and divider numerators (five stages).
// ----------------------------------------------------------------------------
module m3i_det #(
   parameter int ELEM_WIDTH = m3i_pkg::ELEM_WIDTH_DEF,
   parameter int FRAC_BITS  = m3i_pkg::FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [m3i_pkg::THR_WIDTH-1:0]         thr,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  logic signed [ELEM_WIDTH-1:0]          in_row0 [3],
   input  logic signed [2*ELEM_WIDTH:0]          in_cof [m3i_pkg::NUM_ELEM],
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output logic [2*ELEM_WIDTH+2*FRAC_BITS:0]     out_num [m3i_pkg::NUM_ELEM],
   output logic [m3i_pkg::NUM_ELEM-1:0]          out_nneg,
   output logic [3*ELEM_WIDTH+2:0]               out_dmag,
   output logic                                  out_dneg,
   output logic signed [ELEM_WIDTH-1:0]          out_det,
   output logic                                  out_sing
);
   localparam int W    = ELEM_WIDTH;
   localparam int CW   = 2*W + 1;
   localparam int PW   = 3*W + 1;
   localparam int DW   = 3*W + 3;
   localparam int NW   = CW + 2*FRAC_BITS;
   localparam int NE   = m3i_pkg::NUM_ELEM;
   localparam int TW   = m3i_pkg::THR_WIDTH + 2*FRAC_BITS;
   localparam int CMPW = (DW > TW) ? DW : TW;
   localparam int NS   = 5;
   localparam int CI [3] = '{0, 3, 6};

   localparam logic [DW-1:0] HALF = DW'(1) << (W-1);
   localparam logic [W-1:0]  MINV = W'(1) << (W-1);
   localparam logic [W-1:0]  MAXV = ~MINV;

   logic [NS-1:0]         v_ff;
   logic [NS:0]           rdy;

   logic signed [2*W:0]   lo_in  [3];
   logic signed [2*W:0]   hi_in  [3];
   logic signed [2*W:0]   lo_ff  [3];
   logic signed [2*W:0]   hi_ff  [3];
   logic signed [CW-1:0]  cof0_ff [NE];

   logic signed [PW-1:0]  prod_in [3];
   logic signed [PW-1:0]  prod_ff [3];
   logic signed [CW-1:0]  cof1_ff [NE];

   logic signed [DW-1:0]  det_in;
   logic signed [DW-1:0]  det_ff;
   logic signed [CW-1:0]  cof2_ff [NE];

   logic [DW-1:0]         dmag_in;
   logic [DW-1:0]         dmag_ff;
   logic                  dneg_ff;
   logic [CW-1:0]         cmag_in [NE];
   logic [CW-1:0]         cmag_ff [NE];
   logic [NE-1:0]         cneg_ff;

   logic [DW-1:0]         dq;
   logic [W-1:0]          dsat_in;
   logic                  sing_in;
   logic [NW-1:0]         num_in  [NE];
   logic [NW-1:0]         num_ff  [NE];
   logic [NE-1:0]         nneg_ff;
   logic [DW-1:0]         dmag4_ff;
   logic                  dneg4_ff;
   logic signed [W-1:0]   dsat_ff;
   logic                  sing_ff;

   always_comb begin
      rdy[NS] = out_ready;
      for (int k = NS-1; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int k = 1; k < NS; k++) begin
            if (rdy[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // first-row products split into a low unsigned half and a signed high half
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         lo_in[j] = in_row0[j] * $signed({1'b0, in_cof[CI[j]][W-1:0]});
         hi_in[j] = in_row0[j] * $signed(in_cof[CI[j]][CW-1:W]);
         prod_in[j] = $signed({hi_ff[j], {W{1'b0}}})
                    + $signed({{W{lo_ff[j][2*W]}}, lo_ff[j]});
      end
      det_in = $signed({{2{prod_ff[0][PW-1]}}, prod_ff[0]})
             + $signed({{2{prod_ff[1][PW-1]}}, prod_ff[1]})
             + $signed({{2{prod_ff[2][PW-1]}}, prod_ff[2]});
      dmag_in = det_ff[DW-1] ? (~det_ff + 1'b1) : det_ff;
      for (int j = 0; j < NE; j++) begin
         cmag_in[j] = cof2_ff[j][CW-1] ? (~cof2_ff[j] + 1'b1) : cof2_ff[j];
         num_in[j]  = NW'(cmag_ff[j]) << (2*FRAC_BITS);
      end
   end

   // determinant to FRAC_BITS fraction bits, nearest with ties away from zero
   if (FRAC_BITS > 0) begin : g_round
      assign dq = (dmag_ff >> (2*FRAC_BITS)) + DW'(dmag_ff[2*FRAC_BITS-1]);
   end else begin : g_exact
      assign dq = dmag_ff;
   end

   always_comb begin
      if (dneg_ff) begin
         dsat_in = (dq > HALF) ? MINV : (~dq[W-1:0] + 1'b1);
      end else begin
         dsat_in = (dq > HALF - 1'b1) ? MAXV : dq[W-1:0];
      end
      sing_in = (dmag_ff == '0)
             || (CMPW'(dmag_ff) < (CMPW'(thr) << (2*FRAC_BITS)));
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         lo_ff   <= lo_in;
         hi_ff   <= hi_in;
         cof0_ff <= in_cof;
      end
      if (rdy[1]) begin
         prod_ff <= prod_in;
         cof1_ff <= cof0_ff;
      end
      if (rdy[2]) begin
         det_ff  <= det_in;
         cof2_ff <= cof1_ff;
      end
      if (rdy[3]) begin
         dmag_ff <= dmag_in;
         dneg_ff <= det_ff[DW-1];
         cmag_ff <= cmag_in;
         for (int j = 0; j < NE; j++) begin
            cneg_ff[j] <= cof2_ff[j][CW-1];
         end
      end
      if (rdy[4]) begin
         num_ff   <= num_in;
         nneg_ff  <= cneg_ff;
         dmag4_ff <= dmag_ff;
         dneg4_ff <= dneg_ff;
         dsat_ff  <= dsat_in;
         sing_ff  <= sing_in;
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[NS-1];
   assign out_num   = num_ff;
   assign out_nneg  = nneg_ff;
   assign out_dmag  = dmag4_ff;
   assign out_dneg  = dneg4_ff;
   assign out_det   = dsat_ff;
   assign out_sing  = sing_ff;

endmodule

// ===== design/m3i_divide.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3i_divide
// Nine-lane pipelined restoring divider, one quotient bit per stage, with
// overflow check, round-to-nearest step and saturating output register.
// ----------------------------------------------------------------------------
module m3i_divide #(
   parameter int ELEM_WIDTH = m3i_pkg::ELEM_WIDTH_DEF,
   parameter int FRAC_BITS  = m3i_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic [2*ELEM_WIDTH+2*FRAC_BITS:0]  in_num [m3i_pkg::NUM_ELEM],
   input  logic [m3i_pkg::NUM_ELEM-1:0]       in_nneg,
   input  logic [3*ELEM_WIDTH+2:0]            in_dmag,
   input  logic                               in_dneg,
   input  logic signed [ELEM_WIDTH-1:0]       in_det,
   input  logic                               in_sing,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic signed [ELEM_WIDTH-1:0]       out_inv [m3i_pkg::NUM_ELEM],
   output logic signed [ELEM_WIDTH-1:0]       out_det,
   output logic                               out_sing
);
   localparam int W  = ELEM_WIDTH;
   localparam int Q  = W + 1;
   localparam int QR = Q + 1;
   localparam int NW = 2*W + 1 + 2*FRAC_BITS;
   localparam int DW = 3*W + 3;
   localparam int XW = ((NW > DW + Q) ? NW : DW + Q) + 1;
   localparam int NE = m3i_pkg::NUM_ELEM;
   localparam int NS = Q + 3;

   localparam logic [QR-1:0] LIM  = QR'(1) << (W-1);
   localparam logic [W-1:0]  MINV = W'(1) << (W-1);
   localparam logic [W-1:0]  MAXV = ~MINV;

   logic [NS-1:0]       v_ff;
   logic [NS:0]         rdy;

   // overflow stage (index 0) and one stage per quotient bit
   logic [XW-1:0]       r_in    [Q+1][NE];
   logic [XW-1:0]       r_ff    [Q+1][NE];
   logic [Q-1:0]        q_in    [Q+1][NE];
   logic [Q-1:0]        q_ff    [Q+1][NE];
   logic [NE-1:0]       big_in  [Q+1];
   logic [NE-1:0]       big_ff  [Q+1];
   logic [NE-1:0]       sgn_in  [Q+1];
   logic [NE-1:0]       sgn_ff  [Q+1];
   logic [DW-1:0]       d_in    [Q+1];
   logic [DW-1:0]       d_ff    [Q+1];
   logic signed [W-1:0] det_in  [Q+1];
   logic signed [W-1:0] det_ff  [Q+1];
   logic [Q:0]          sing_in;
   logic [Q:0]          sing_ff;

   logic [QR-1:0]       rq_in   [NE];
   logic [QR-1:0]       rq_ff   [NE];
   logic [NE-1:0]       rbig_ff;
   logic [NE-1:0]       rsgn_ff;
   logic signed [W-1:0] rdet_ff;
   logic                rsing_ff;

   logic signed [W-1:0] inv_in  [NE];
   logic signed [W-1:0] inv_ff  [NE];
   logic signed [W-1:0] odet_ff;
   logic                osing_ff;

   always_comb begin
      rdy[NS] = out_ready;
      for (int k = NS-1; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int k = 1; k < NS; k++) begin
            if (rdy[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   always_comb begin
      logic ge;
      ge = 1'b0;
      for (int j = 0; j < NE; j++) begin
         r_in[0][j]   = XW'(in_num[j]);
         q_in[0][j]   = '0;
         big_in[0][j] = XW'(in_num[j]) >= (XW'(in_dmag) << Q);
      end
      sgn_in[0]  = in_nneg ^ {NE{in_dneg}};
      d_in[0]    = in_dmag;
      det_in[0]  = in_det;
      sing_in[0] = in_sing;
      // stage k settles quotient bit Q-k
      for (int k = 1; k <= Q; k++) begin
         for (int j = 0; j < NE; j++) begin
            ge = r_ff[k-1][j] >= (XW'(d_ff[k-1]) << (Q-k));
            r_in[k][j] = ge ? (r_ff[k-1][j] - (XW'(d_ff[k-1]) << (Q-k)))
                            : r_ff[k-1][j];
            q_in[k][j] = q_ff[k-1][j];
            q_in[k][j][Q-k] = ge;
         end
         big_in[k]  = big_ff[k-1];
         sgn_in[k]  = sgn_ff[k-1];
         d_in[k]    = d_ff[k-1];
         det_in[k]  = det_ff[k-1];
         sing_in[k] = sing_ff[k-1];
      end
      // round up when twice the remainder reaches the divisor
      for (int j = 0; j < NE; j++) begin
         rq_in[j] = QR'(q_ff[Q][j]) + QR'((r_ff[Q][j] << 1) >= XW'(d_ff[Q]));
      end
      for (int j = 0; j < NE; j++) begin
         if (rsing_ff) begin
            inv_in[j] = '0;
         end else if (rsgn_ff[j]) begin
            inv_in[j] = (rbig_ff[j] || rq_ff[j] > LIM) ? MINV
                                                       : (~rq_ff[j][W-1:0] + 1'b1);
         end else begin
            inv_in[j] = (rbig_ff[j] || rq_ff[j] > LIM - 1'b1) ? MAXV
                                                              : rq_ff[j][W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= Q; k++) begin
         if (rdy[k]) begin
            r_ff[k]    <= r_in[k];
            q_ff[k]    <= q_in[k];
            big_ff[k]  <= big_in[k];
            sgn_ff[k]  <= sgn_in[k];
            d_ff[k]    <= d_in[k];
            det_ff[k]  <= det_in[k];
            sing_ff[k] <= sing_in[k];
         end
      end
      if (rdy[Q+1]) begin
         rq_ff    <= rq_in;
         rbig_ff  <= big_ff[Q];
         rsgn_ff  <= sgn_ff[Q];
         rdet_ff  <= det_ff[Q];
         rsing_ff <= sing_ff[Q];
      end
      if (rdy[Q+2]) begin
         inv_ff   <= inv_in;
         odet_ff  <= rdet_ff;
         osing_ff <= rsing_ff;
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[NS-1];
   assign out_inv   = inv_ff;
   assign out_det   = odet_ff;
   assign out_sing  = osing_ff;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench for matrix3x3_inverse_top
// Streams 3x3 Q16.16 matrices through the inverse pipeline under random
// bursts and back-pressure, predicts every inverse, determinant and singular
// flag with wide exact arithmetic, and checks each result in order. The
// singular threshold is rewritten between phases while the pipeline is empty.
// ----------------------------------------------------------------------------
module testbench;

   localparam int EW          = 32;
   localparam int FB          = 16;
   localparam int DRAIN_WAIT  = EW + 20;
   localparam int IDLE_LIMIT  = 3000;
   localparam int PHASE_ITEMS = 130;

   typedef logic signed [EW-1:0] elem_type;
   typedef logic signed [199:0] wide_type;

   typedef struct {
      elem_type a[m3i_pkg::NUM_ELEM];
   } matrix_type;

   typedef struct {
      elem_type inv[m3i_pkg::NUM_ELEM];
      elem_type det;
      logic     sing;
   } inverse_type;

   class inverse_scoreboard;
      inverse_type                   expected_q[$];
      logic [m3i_pkg::THR_WIDTH-1:0] threshold;
      int                            errors;
      int                            checked;
      int                            singular_seen;

      function new();
         threshold     = m3i_pkg::THR_RESET;
         errors        = 0;
         checked       = 0;
         singular_seen = 0;
      endfunction

      task report(string what, int idx, elem_type got, elem_type want);
         errors++;
         if (errors <= 40)
            $display("mismatch result %0d: %s got %0d expected %0d", idx, what, got, want);
      endtask

      // exact quotient rounded to nearest, ties away from zero
      function wide_type round_div(wide_type n, wide_type d);
         logic [199:0] nm, dm, q, r;
         nm = n < 0 ? -n : n;
         dm = d < 0 ? -d : d;
         q  = nm / dm;
         r  = nm % dm;
         if ((r << 1) >= dm) q = q + 1;
         return ((n < 0) != (d < 0)) ? -$signed(q) : $signed(q);
      endfunction

      function elem_type saturate(wide_type v);
         if (v > wide_type'(32'sh7FFFFFFF)) return 32'sh7FFFFFFF;
         if (v < -wide_type'(64'sh80000000)) return 32'sh80000000;
         return elem_type'(v);
      endfunction

      function void note_matrix(matrix_type m);
         wide_type    x[m3i_pkg::NUM_ELEM], c[m3i_pkg::NUM_ELEM], det, thr, dmag;
         inverse_type e;
         for (int i = 0; i < m3i_pkg::NUM_ELEM; i++) x[i] = m.a[i];
         c[0] = x[4] * x[8] - x[5] * x[7];
         c[1] = x[2] * x[7] - x[1] * x[8];
         c[2] = x[1] * x[5] - x[2] * x[4];
         c[3] = x[5] * x[6] - x[3] * x[8];
         c[4] = x[0] * x[8] - x[2] * x[6];
         c[5] = x[2] * x[3] - x[0] * x[5];
         c[6] = x[3] * x[7] - x[4] * x[6];
         c[7] = x[1] * x[6] - x[0] * x[7];
         c[8] = x[0] * x[4] - x[1] * x[3];
         det = x[0] * c[0] + x[1] * c[3] + x[2] * c[6];
         e.det = saturate(round_div(det, wide_type'(1) <<< (2 * FB)));
         thr  = wide_type'({1'b0, threshold}) <<< (2 * FB);
         dmag = det < 0 ? -det : det;
         e.sing = (det == 0) || (dmag < thr);
         for (int i = 0; i < m3i_pkg::NUM_ELEM; i++)
            e.inv[i] = e.sing ? '0 : saturate(round_div(c[i] <<< (2 * FB), det));
         expected_q.push_back(e);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      task check_result(inverse_type got);
         inverse_type want;
         if (expected_q.size() == 0) begin
            errors++;
            $display("unexpected result with nothing outstanding");
            return;
         end
         want = expected_q.pop_front();
         for (int i = 0; i < m3i_pkg::NUM_ELEM; i++)
            if (got.inv[i] !== want.inv[i])
               report($sformatf("inv[%0d]", i), checked, got.inv[i], want.inv[i]);
         if (got.det !== want.det) report("determinant", checked, got.det, want.det);
         if (got.sing !== want.sing)
            report("singular", checked, elem_type'(got.sing), elem_type'(want.sing));
         if (want.sing) singular_seen++;
         checked++;
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [m3i_pkg::THR_WIDTH-1:0] csr_wdata = '0;
   logic req_valid = 0;
   logic req_ready;
   elem_type req_a[m3i_pkg::NUM_ELEM];
   logic rsp_valid;
   logic rsp_ready = 0;
   elem_type rsp_inv[m3i_pkg::NUM_ELEM];
   elem_type rsp_determinant;
   logic rsp_singular;

   inverse_scoreboard sb = new();
   int idle_cycles = 0;
   int items_sent = 0;
   int stall_mode = 0;
   int stall_left = 0;

   initial for (int i = 0; i < m3i_pkg::NUM_ELEM; i++) req_a[i] = '0;

   always #4 clock = ~clock;

   matrix3x3_inverse_top #(.ELEM_WIDTH(EW), .FRAC_BITS(FB)) dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_a_r0c0(req_a[0]), .req_a_r0c1(req_a[1]), .req_a_r0c2(req_a[2]),
      .req_a_r1c0(req_a[3]), .req_a_r1c1(req_a[4]), .req_a_r1c2(req_a[5]),
      .req_a_r2c0(req_a[6]), .req_a_r2c1(req_a[7]), .req_a_r2c2(req_a[8]),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_inv_r0c0(rsp_inv[0]), .rsp_inv_r0c1(rsp_inv[1]), .rsp_inv_r0c2(rsp_inv[2]),
      .rsp_inv_r1c0(rsp_inv[3]), .rsp_inv_r1c1(rsp_inv[4]), .rsp_inv_r1c2(rsp_inv[5]),
      .rsp_inv_r2c0(rsp_inv[6]), .rsp_inv_r2c1(rsp_inv[7]), .rsp_inv_r2c2(rsp_inv[8]),
      .rsp_determinant(rsp_determinant), .rsp_singular(rsp_singular)
   );

   // receiver: checks results, stalls in stretches, watchdog on silence
   always @(posedge clock) begin
      inverse_type got;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            for (int i = 0; i < m3i_pkg::NUM_ELEM; i++) got.inv[i] = rsp_inv[i];
            got.det  = rsp_determinant;
            got.sing = rsp_singular;
            sb.check_result(got);
         end
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
            $display("FAIL matrix3x3_inverse_top");
            $finish;
         end
      end
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(5, 60);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= $urandom_range(0, 1);
         2: rsp_ready <= ($urandom_range(0, 7) != 0);
         default: rsp_ready <= (stall_left < 3);
      endcase
   end

   task drive_matrix(matrix_type m);
      req_valid <= 1'b1;
      for (int i = 0; i < m3i_pkg::NUM_ELEM; i++) req_a[i] <= m.a[i];
      do @(posedge clock); while (!req_ready);
      sb.note_matrix(m);
      items_sent++;
   endtask

   task write_threshold(logic [m3i_pkg::THR_WIDTH-1:0] v);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.threshold = v;
   endtask

   function elem_type any_elem();
      return $signed($urandom) >>> $urandom_range(0, 31);
   endfunction

   function matrix_type random_matrix();
      matrix_type m;
      int         kind;
      kind = $urandom_range(0, 9);
      for (int i = 0; i < m3i_pkg::NUM_ELEM; i++) m.a[i] = any_elem();
      if (kind <= 4) begin
         // well conditioned: dominant diagonal around a few units
         for (int i = 0; i < m3i_pkg::NUM_ELEM; i++)
            m.a[i] = $signed($urandom_range(0, 1 << 17)) - (1 << 16);
         for (int i = 0; i < 3; i++)
            m.a[4 * i] = ($urandom_range(0, 1) ? 1 : -1)
                         * ($signed($urandom_range(1 << 16, 1 << 19)));
      end else if (kind == 5) begin
         // singular when signs agree: row 0 copied into row 2, each element possibly negated
         for (int i = 0; i < 3; i++)
            m.a[6 + i] = $urandom_range(0, 1) ? m.a[i] : -m.a[i];
      end else if (kind == 6) begin
         // tiny elements, determinant near the threshold
         for (int i = 0; i < m3i_pkg::NUM_ELEM; i++)
            m.a[i] = $signed($urandom_range(0, 1 << 12)) - (1 << 11);
      end else if (kind == 7) begin
         for (int i = 0; i < m3i_pkg::NUM_ELEM; i++) m.a[i] = $urandom;
      end
      return m;
   endfunction

   task run_items(int count);
      int burst;
      burst = 0;
      for (int n = 0; n < count; n++) begin
         if (burst == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
            burst = $urandom_range(1, 40);
         end
         drive_matrix(random_matrix());
         burst--;
      end
      req_valid <= 1'b0;
   endtask

   task run_directed();
      matrix_type m;
      elem_type   vals[6];
      vals = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh00010000, -32'sh00010000, 0, 1};
      foreach (vals[v]) begin
         for (int i = 0; i < m3i_pkg::NUM_ELEM; i++) m.a[i] = vals[v];
         drive_matrix(m);
         for (int i = 0; i < m3i_pkg::NUM_ELEM; i++)
            m.a[i] = (i % 4 == 0) ? vals[v] : 0;
         drive_matrix(m);
      end
      // alternating extremes give a huge determinant
      for (int i = 0; i < m3i_pkg::NUM_ELEM; i++)
         m.a[i] = ((i == 0) || (i == 4) || (i == 8)) ? 32'sh7FFFFFFF : 32'sh80000000;
      drive_matrix(m);
      // small scaled identity whose determinant falls below the threshold
      for (int i = 0; i < m3i_pkg::NUM_ELEM; i++)
         m.a[i] = (i % 4 == 0) ? 32'sh00000100 : 0;
      drive_matrix(m);
      // determinant magnitude exactly at one unit of threshold
      for (int i = 0; i < m3i_pkg::NUM_ELEM; i++)
         m.a[i] = (i % 4 == 0) ? 32'sh00010000 : 0;
      m.a[0] = 32'sh00000001;
      drive_matrix(m);
      m.a[0] = 32'sh00000000; m.a[1] = 32'sh00000001; m.a[3] = 32'sh00010000;
      drive_matrix(m);
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      logic [m3i_pkg::THR_WIDTH-1:0] thresholds[5];
      thresholds = '{m3i_pkg::THR_RESET, '0, {m3i_pkg::THR_WIDTH{1'b1}}, 31'h00010000,
                     m3i_pkg::THR_WIDTH'($urandom)};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      for (int p = 0; p < 5; p++) begin
         write_threshold(thresholds[p]);
         if (p == 0 || p == 2) run_directed();
         run_items(PHASE_ITEMS);
      end
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("sent %0d matrices over 5 threshold settings, %0d results checked",
               items_sent, sb.checked);
      $display("%0d results were singular, %0d mismatches", sb.singular_seen, sb.errors);
      if (sb.errors == 0)
         $display("PASS matrix3x3_inverse_top");
      else
         $display("FAIL matrix3x3_inverse_top");
      $finish;
   end

endmodule

// ===== sim.f =====
design/m3i_pkg.sv
design/m3i_cofactor.sv
design/m3i_det.sv
design/m3i_divide.sv
design/matrix3x3_inverse_top.sv
tb/testbench.sv
